>>> sv/u8t16_pkg.sv
`default_nettype none

package u8t16_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [20:0] scalar_value;
      logic        bad_encoding;
      logic        run_last;
      logic        stream_done;
   } rsp_payload_type;

   // What the character position of a job turns into.
   typedef enum logic [1:0] {
      CHAR_NONE = 2'd0,
      CHAR_BMP  = 2'd1,
      CHAR_SUPP = 2'd2,
      CHAR_ERR  = 2'd3
   } char_kind_type;

   // One accepted input word as the back end sees it.
   typedef struct packed {
      logic          bom;
      logic          err_first;
      char_kind_type kind;
      logic [20:0]   cp;
      logic          err_last;
      logic          stream_end;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Output byte positions of a job, in the order they are sent.
   localparam logic [2:0] SLOT_BOM_HI    = 3'd0;
   localparam logic [2:0] SLOT_BOM_LO    = 3'd1;
   localparam logic [2:0] SLOT_ERR_FIRST = 3'd2;
   localparam logic [2:0] SLOT_CHAR_0    = 3'd3;
   localparam logic [2:0] SLOT_CHAR_1    = 3'd4;
   localparam logic [2:0] SLOT_CHAR_2    = 3'd5;
   localparam logic [2:0] SLOT_CHAR_3    = 3'd6;
   localparam logic [2:0] SLOT_ERR_LAST  = 3'd7;

   localparam logic [7:0]  BOM_HI_BYTE = 8'hFE;
   localparam logic [7:0]  BOM_LO_BYTE = 8'hFF;
   localparam logic [20:0] CP_MAX      = 21'h10FFFF;
   localparam logic [20:0] SUPP_BASE   = 21'h010000;

endpackage

`default_nettype wire

>>> sv/u8t16_chan_if.sv
`default_nettype none

interface u8t16_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/u8t16_front.sv
`default_nettype none

module u8t16_front (
   input  wire                      clock,
   input  wire                      reset,
   u8t16_chan_if.sink               req_if,
   u8t16_chan_if.sink               csr_if,
   input  u8t16_pkg::queue_status_type q_status,
   output logic                     push,
   output u8t16_pkg::job_type       job
);
   import u8t16_pkg::*;

   logic        emit_bom_ff;
   logic [1:0]  pend_ff, pend_in;
   logic [20:0] pp_ff, pp_in;
   logic        bom_pending_ff, bom_pending_in;
   logic [7:0]  b;
   logic [20:0] pp_cat;
   logic        do_lead;
   logic        any_result;
   logic        accept;

   function automatic char_kind_type classify(input logic [20:0] cp);
      char_kind_type k;
      if (cp > CP_MAX) begin
         k = CHAR_ERR;
      end else if (cp < SUPP_BASE) begin
         k = CHAR_BMP;
      end else begin
         k = CHAR_SUPP;
      end
      return k;
   endfunction

   assign b         = req_if.payload.in_byte;
   assign req_if.ready = !q_status.full;
   assign csr_if.ready = 1'b1;
   assign accept    = req_if.valid && req_if.ready;
   assign pp_cat    = {pp_ff[14:0], b[5:0]};

   always_comb begin
      pend_in        = pend_ff;
      pp_in          = pp_ff;
      bom_pending_in = bom_pending_ff;
      do_lead        = 1'b0;
      job.bom        = 1'b0;
      job.err_first  = 1'b0;
      job.kind       = CHAR_NONE;
      job.cp         = 21'd0;
      job.err_last   = 1'b0;
      job.stream_end = req_if.payload.stream_end;

      if (pend_ff != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            pend_in = pend_ff - 2'd1;
            if (pend_in == 2'd0) begin
               job.kind = classify(pp_cat);
               job.cp   = (classify(pp_cat) == CHAR_ERR) ? 21'd0 : pp_cat;
               pp_in    = 21'd0;
            end else begin
               pp_in = pp_cat;
            end
         end else begin
            // The broken sequence reports first; this byte then starts over.
            job.err_first = 1'b1;
            pend_in       = 2'd0;
            pp_in         = 21'd0;
            do_lead       = 1'b1;
         end
      end else begin
         do_lead = 1'b1;
      end

      if (do_lead) begin
         case (b) inside
            8'b0???????: begin
               job.kind = CHAR_BMP;
               job.cp   = {13'd0, b};
            end
            8'b110?????: begin
               pp_in   = {16'd0, b[4:0]};
               pend_in = 2'd1;
            end
            8'b1110????: begin
               pp_in   = {17'd0, b[3:0]};
               pend_in = 2'd2;
            end
            8'b11110???: begin
               pp_in   = {18'd0, b[2:0]};
               pend_in = 2'd3;
            end
            default: begin
               job.kind = CHAR_ERR;
            end
         endcase
      end

      if (req_if.payload.stream_end) begin
         job.err_last   = (pend_in != 2'd0);
         pend_in        = 2'd0;
         pp_in          = 21'd0;
      end

      any_result = job.err_first || (job.kind != CHAR_NONE) || job.err_last;
      job.bom    = bom_pending_ff && emit_bom_ff && any_result;

      if (req_if.payload.stream_end) begin
         bom_pending_in = 1'b1;
      end else if (any_result) begin
         bom_pending_in = 1'b0;
      end
   end

   assign push = accept && any_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_bom_ff    <= 1'b1;
         pend_ff        <= 2'd0;
         pp_ff          <= 21'd0;
         bom_pending_ff <= 1'b1;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            emit_bom_ff <= csr_if.payload;
         end
         if (accept) begin
            pend_ff        <= pend_in;
            pp_ff          <= pp_in;
            bom_pending_ff <= bom_pending_in;
         end
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.payload.stream_end) |=> (pend_ff == 2'd0) && bom_pending_ff)
      else $error("stream end did not clear the decoder state");

   a_end_has_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.payload.stream_end) |-> push)
      else $error("stream end produced no job");

   a_pending_partial: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == 2'd0) |-> (pp_ff == 21'd0))
      else $error("partial code point left without pending bytes");

endmodule

`default_nettype wire

>>> sv/u8t16_queue.sv
`default_nettype none

module u8t16_queue #(
   parameter int DEPTH = 2
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  u8t16_pkg::job_type          wr_job,
   input  wire                         pop,
   output u8t16_pkg::job_type          head,
   output u8t16_pkg::queue_status_type status
);
   import u8t16_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("job written into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("job taken from an empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

>>> sv/u8t16_back.sv
`default_nettype none

module u8t16_back (
   input  wire                         clock,
   input  wire                         reset,
   input  u8t16_pkg::job_type          head,
   input  u8t16_pkg::queue_status_type q_status,
   output logic                        pop,
   u8t16_chan_if.source                rsp_if
);
   import u8t16_pkg::*;

   logic [2:0]      slot_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type word;
   logic [7:0]      mask, avail, rest;
   logic [2:0]      cur;
   logic            last;
   logic            advance;
   logic [19:0]     v;
   logic [15:0]     hi_unit, lo_unit;

   always_comb begin
      mask = 8'd0;
      mask[SLOT_BOM_HI]    = head.bom;
      mask[SLOT_BOM_LO]    = head.bom;
      mask[SLOT_ERR_FIRST] = head.err_first;
      mask[SLOT_CHAR_0]    = (head.kind != CHAR_NONE);
      mask[SLOT_CHAR_1]    = (head.kind == CHAR_BMP) || (head.kind == CHAR_SUPP);
      mask[SLOT_CHAR_2]    = (head.kind == CHAR_SUPP);
      mask[SLOT_CHAR_3]    = (head.kind == CHAR_SUPP);
      mask[SLOT_ERR_LAST]  = head.err_last;
   end

   assign avail = mask & (8'hFF << slot_ff);

   always_comb begin
      cur = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (avail[i]) begin
            cur = 3'(i);
         end
      end
   end

   assign rest = avail & ~(8'd1 << cur);
   assign last = (rest == 8'd0);

   // Surrogate pair for code points above the basic plane.
   assign v       = 20'(head.cp - SUPP_BASE);
   assign hi_unit = {6'b110110, v[19:10]};
   assign lo_unit = {6'b110111, v[9:0]};

   always_comb begin
      word.out_byte     = 8'd0;
      word.scalar_value = head.cp;
      word.bad_encoding = 1'b0;
      word.run_last     = last;
      word.stream_done  = last && head.stream_end;
      case (cur)
         SLOT_BOM_HI: begin
            word.out_byte     = BOM_HI_BYTE;
            word.scalar_value = 21'd0;
         end
         SLOT_BOM_LO: begin
            word.out_byte     = BOM_LO_BYTE;
            word.scalar_value = 21'd0;
         end
         SLOT_ERR_FIRST, SLOT_ERR_LAST: begin
            word.scalar_value = 21'd0;
            word.bad_encoding = 1'b1;
         end
         SLOT_CHAR_0: begin
            if (head.kind == CHAR_ERR) begin
               word.scalar_value = 21'd0;
               word.bad_encoding = 1'b1;
            end else if (head.kind == CHAR_SUPP) begin
               word.out_byte = hi_unit[15:8];
            end else begin
               word.out_byte = head.cp[15:8];
            end
         end
         SLOT_CHAR_1: begin
            word.out_byte = (head.kind == CHAR_SUPP) ? hi_unit[7:0] : head.cp[7:0];
         end
         SLOT_CHAR_2: begin
            word.out_byte = lo_unit[15:8];
         end
         SLOT_CHAR_3: begin
            word.out_byte = lo_unit[7:0];
         end
         default: begin
            word.out_byte = 8'd0;
         end
      endcase
   end

   assign advance = !q_status.empty && (!rsp_valid_ff || rsp_if.ready);
   assign pop     = advance && last;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            slot_ff      <= last ? 3'd0 : cur + 3'd1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   a_mid_job_has_head: assert property (@(posedge clock) disable iff (reset)
      (slot_ff != 3'd0) |-> !q_status.empty)
      else $error("job position set with no job queued");

   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (avail != 8'd0))
      else $error("queued job has no byte left to send");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.stream_done) |-> rsp_ff.run_last)
      else $error("stream end flagged on a word that is not the last of its input");

endmodule

`default_nettype wire

>>> sv/utf8_to_utf16be_transcoder_core.sv
// UTF-8 to UTF-16 big-endian transcoder.
// req_if takes one UTF-8 byte per word with stream_end on the final byte of a stream.
// rsp_if gives one UTF-16BE byte per word, with its code point, an error flag,
// run_last on the last word caused by an input byte and stream_done on the last
// word of a stream. Malformed input gives a single zero byte with bad_encoding set.
// csr_if writes emit_bom; with it set, FE FF precede the first word of each stream.
// Throughput: one result word per cycle unless the receiver stalls. An ASCII byte
// gives two words, so a run of them is paced by the output; longer sequences give at
// most one word per input byte and run at one input per cycle. The back end sets the
// output rate; the front end accepts a byte per cycle while the job queue has room.
// An accepted byte's job is written into the job queue; the back end then loads its
// first result word from the queue head into the output register.
// When the receiver stalls, the result register holds its word, the job queue
// fills, and req_if.ready drops once QUEUE_DEPTH jobs are waiting.
// Reset clears the decoder state and the queue, sets emit_bom to 1 and arms the
// byte order mark for the next stream; no result is pending after reset.
`default_nettype none

module utf8_to_utf16be_transcoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire          clock,
   input  wire          reset,
   u8t16_chan_if.sink   req_if,
   u8t16_chan_if.sink   csr_if,
   u8t16_chan_if.source rsp_if
);
   import u8t16_pkg::*;

   logic             push;
   logic             pop;
   job_type          wr_job;
   job_type          head;
   queue_status_type q_status;

   u8t16_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .csr_if   (csr_if),
      .q_status (q_status),
      .push     (push),
      .job      (wr_job)
   );

   u8t16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_job (wr_job),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   u8t16_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire
